// ===== design/aesrr_pkg.sv =====
// Shared types, constants and helper functions for the reduced-round AES encryptor.
package aesrr_pkg;

    localparam int NUM_LANES = 4;
    localparam int MAX_ROUNDS = 10;

    localparam logic [7:0] RED_STD = 8'h1B;
    localparam logic [7:0] RED_ALT = 8'h7B;

    typedef enum logic [2:0] {
        REG_ROUND_COUNT  = 3'd0,
        REG_FINAL_MIXES  = 3'd1,
        REG_REDUCTION    = 3'd2,
        REG_KEY_HIGH     = 3'd3,
        REG_KEY_LOW      = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        KIND_ENCRYPT   = 1'b0,
        KIND_SBOX_WRITE = 1'b1
    } item_kind_t;

    // One write into every copy of the substitution table.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } sbox_wr_t;

    localparam logic [7:0] SBOX_INIT [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon_of(logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1B;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] p, logic sel);
        logic [7:0] mask;
        mask = p[7] ? (sel ? RED_ALT : RED_STD) : 8'h00;
        return {p[6:0], 1'b0} ^ mask;
    endfunction

endpackage

// ===== design/aesrr_if.sv =====
// Handshake channel interfaces: item input, result output and register writes.
interface aesrr_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [7:0]  sbox_index;
    logic [7:0]  sbox_value;
    modport source (output valid, kind, block_high, block_low, sbox_index, sbox_value,
                    input ready);
    modport sink (input valid, kind, block_high, block_low, sbox_index, sbox_value,
                  output ready);
endinterface

interface aesrr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

interface aesrr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/aes128_reduced_round_encryptor.sv =====
// AES-128 encryptor with a configurable number of rounds (1 to 10, 0 acts as 1 and values
// above 10 act as 10) and an on-the-fly key schedule. An encrypt transfer first loads the
// block (plaintext XOR key, first lookups issued) and then runs its rounds, each closed by
// the registered read of the substitution tables. The state is split into four column
// lanes, each with four private copies of the table, and a key lane with four more copies;
// all twenty copies are written together. An S-box write transfer updates one entry and
// produces no result. After reset the tables are loaded with the standard AES S-box by a
// pass over all 256 entries during which no item transfer is taken; register writes are
// taken at any time. The finished ciphertext sits in an output register, and a new item
// can be taken while it waits; a block whose last round is ready while the previous result
// is still unread holds until it is taken.
module aes128_reduced_round_encryptor
    import aesrr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    aesrr_in_if.sink     in_ch,
    aesrr_out_if.source  out_ch,
    aesrr_cfg_if.sink    cfg_ch
);

    // Configuration registers.
    logic [3:0]  round_count_reg;
    logic        final_mixes_reg;
    logic        red_sel_reg;
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= 4'd10;
            final_mixes_reg <= 1'b0;
            red_sel_reg     <= 1'b0;
            key_high_reg    <= '0;
            key_low_reg     <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_ROUND_COUNT: round_count_reg <= cfg_ch.data[3:0];
                REG_FINAL_MIXES: final_mixes_reg <= cfg_ch.data[0];
                REG_REDUCTION:   red_sel_reg     <= cfg_ch.data[0];
                REG_KEY_HIGH:    key_high_reg    <= cfg_ch.data;
                REG_KEY_LOW:     key_low_reg     <= cfg_ch.data;
                default:         ;
            endcase
        end
    end

    // Table load after reset: one entry per cycle into every copy.
    logic [8:0] clr_reg;
    logic       clearing;

    assign clearing = !clr_reg[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 9'd1;
        end
    end

    // Round control.
    logic         busy_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] key_reg;
    logic         out_valid_reg;
    logic [127:0] cipher_reg;

    logic [3:0] num_rounds;
    logic       last;
    logic       finish;
    logic       in_fire;
    logic       load;
    logic       rd_en;

    always_comb
    begin
        if (round_count_reg == 4'd0)
        begin
            num_rounds = 4'd1;
        end
        else if (round_count_reg > 4'(MAX_ROUNDS))
        begin
            num_rounds = 4'(MAX_ROUNDS);
        end
        else
        begin
            num_rounds = round_count_reg;
        end
    end

    assign in_ch.ready = !clearing && !busy_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign load        = in_fire && (in_ch.kind == KIND_ENCRYPT);
    assign last        = (rnd_reg == num_rounds - 4'd1);
    assign finish      = busy_reg && last && (!out_valid_reg || out_ch.ready);
    assign rd_en       = load || (busy_reg && !last);

    sbox_wr_t wr;

    always_comb
    begin
        if (clearing)
        begin
            wr.en   = 1'b1;
            wr.addr = clr_reg[7:0];
            wr.data = SBOX_INIT[clr_reg[7:0]];
        end
        else
        begin
            wr.en   = in_fire && (in_ch.kind == KIND_SBOX_WRITE);
            wr.addr = in_ch.sbox_index;
            wr.data = in_ch.sbox_value;
        end
    end

    // Lookup addresses: the initial key addition on load, the finished round otherwise.
    logic [127:0] master_key;
    logic [127:0] key_next;
    logic [127:0] mixed_state;
    logic [127:0] round_out;
    logic [127:0] st_addr;
    logic [127:0] key_addr;
    logic [31:0]  key_rot;
    logic         mix_en;

    assign master_key = {key_high_reg, key_low_reg};
    assign round_out  = mixed_state ^ key_next;
    assign st_addr    = load ? ({in_ch.block_high, in_ch.block_low} ^ master_key) : round_out;
    assign key_addr   = load ? master_key : key_next;
    assign key_rot    = {key_addr[23:0], key_addr[31:24]};
    assign mix_en     = !last || final_mixes_reg;

    // Column lanes; ShiftRows is the choice of source byte for each row.
    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        logic [31:0] lane_addr;
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            assign lane_addr[31-8*r -: 8] = st_addr[127-8*(r+4*((c+r)%4)) -: 8];
        end
        aesrr_col_lane u_lane (
            .clk     (clk),
            .wr      (wr),
            .rd_en   (rd_en),
            .addr    (lane_addr),
            .mix_en  (mix_en),
            .red_sel (red_sel_reg),
            .col     (mixed_state[127-32*c -: 32])
        );
    end

    aesrr_key_lane u_key (
        .clk      (clk),
        .wr       (wr),
        .rd_en    (rd_en),
        .addr     (key_rot),
        .key      (key_reg),
        .rcon     (rcon_of(rnd_reg)),
        .key_next (key_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg && !last)
            begin
                rnd_reg <= rnd_reg + 4'd1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the round key follows the rounds, the result is captured on finish.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= master_key;
        end
        else if (busy_reg && !last)
        begin
            key_reg <= key_next;
        end
        if (finish)
        begin
            cipher_reg <= round_out;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.cipher_high = cipher_reg[127:64];
    assign out_ch.cipher_low  = cipher_reg[63:0];

`ifndef ASSERT_OFF
    // No item is taken while the tables are still being loaded.
    a_no_item_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_fire)
        else $error("item transfer during table load");

    // The round counter never runs past the last round.
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rnd_reg < num_rounds))
        else $error("round counter out of range");

    // A block whose last round is held by a full output stays in flight.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last && !finish) |=> (busy_reg && $stable(rnd_reg)))
        else $error("held block lost");

    // A result appears only at the end of a block.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(finish))
        else $error("result without finished block");
`endif

endmodule

// ===== design/aesrr_ram.sv =====
// One 256 x 8 copy of the substitution table with a registered read port.
module aesrr_ram
    import aesrr_pkg::*;
(
    input  logic       clk,
    input  sbox_wr_t   wr,
    input  logic       rd_en,
    input  logic [7:0] rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0] mem [256];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/aesrr_col_lane.sv =====
// One column lane: four table lookups followed by an optional MixColumns.
module aesrr_col_lane
    import aesrr_pkg::*;
(
    input  logic        clk,
    input  sbox_wr_t    wr,
    input  logic        rd_en,
    input  logic [31:0] addr,
    input  logic        mix_en,
    input  logic        red_sel,
    output logic [31:0] col
);

    logic [7:0] s [4];

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        aesrr_ram u_ram (
            .clk     (clk),
            .wr      (wr),
            .rd_en   (rd_en),
            .rd_addr (addr[31-8*r -: 8]),
            .rd_data (s[r])
        );
    end

    logic [7:0] t;
    logic [31:0] mixed;

    always_comb
    begin
        t = s[0] ^ s[1] ^ s[2] ^ s[3];
        mixed[31:24] = s[0] ^ t ^ xtime(s[0] ^ s[1], red_sel);
        mixed[23:16] = s[1] ^ t ^ xtime(s[1] ^ s[2], red_sel);
        mixed[15:8]  = s[2] ^ t ^ xtime(s[2] ^ s[3], red_sel);
        mixed[7:0]   = s[3] ^ t ^ xtime(s[3] ^ s[0], red_sel);
    end

    assign col = mix_en ? mixed : {s[0], s[1], s[2], s[3]};

endmodule

// ===== design/aesrr_key_lane.sv =====
// Key schedule lane: four table lookups on the rotated last word, then the next round key.
module aesrr_key_lane
    import aesrr_pkg::*;
(
    input  logic         clk,
    input  sbox_wr_t     wr,
    input  logic         rd_en,
    input  logic [31:0]  addr,
    input  logic [127:0] key,
    input  logic [7:0]   rcon,
    output logic [127:0] key_next
);

    logic [7:0] s [4];

    for (genvar r = 0; r < 4; r++)
    begin : g_byte
        aesrr_ram u_ram (
            .clk     (clk),
            .wr      (wr),
            .rd_en   (rd_en),
            .rd_addr (addr[31-8*r -: 8]),
            .rd_data (s[r])
        );
    end

    logic [31:0] w0, w1, w2, w3;

    always_comb
    begin
        w0 = key[127:96] ^ {s[0] ^ rcon, s[1], s[2], s[3]};
        w1 = key[95:64] ^ w0;
        w2 = key[63:32] ^ w1;
        w3 = key[31:0] ^ w2;
    end

    assign key_next = {w0, w1, w2, w3};

endmodule

// ===== dv/aesrr_checker.sv =====
// Checker for the reduced-round AES encryptor: predicts ciphertexts and compares results.
module aesrr_checker
    import aesrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aesrr_in_if.sink    in_mon,
    aesrr_out_if.sink   out_mon,
    aesrr_cfg_if.sink   cfg_mon,
    output int          fail_count,
    output int          cipher_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_t;

    logic [7:0]  table_copy [256];
    logic [3:0]  rounds_cfg;
    logic        final_mix_cfg;
    logic        alt_red_cfg;
    logic [63:0] key_hi_cfg;
    logic [63:0] key_lo_cfg;
    cipher_t     cipher_queue [$];

    function automatic logic [7:0] mul2(logic [7:0] p);
        return {p[6:0], 1'b0} ^ (p[7] ? (alt_red_cfg ? 8'h7B : 8'h1B) : 8'h00);
    endfunction

    function automatic cipher_t encrypt_block(logic [63:0] hi, logic [63:0] lo);
        logic [7:0] b [16];
        logic [7:0] k [16];
        logic [7:0] s [16];
        logic [7:0] nk [16];
        logic [7:0] rc [10];
        logic [7:0] a0, a1, a2, a3, t;
        logic [127:0] pt, kt;
        cipher_t res;
        int n;
        rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};
        n = rounds_cfg;
        if (n < 1) n = 1;
        if (n > 10) n = 10;
        pt = {hi, lo};
        kt = {key_hi_cfg, key_lo_cfg};
        for (int i = 0; i < 16; i++)
        begin
            k[i] = kt[127 - 8 * i -: 8];
            b[i] = pt[127 - 8 * i -: 8] ^ k[i];
        end
        for (int r = 0; r < n; r++)
        begin
            nk[0] = k[0] ^ table_copy[k[13]] ^ rc[r];
            nk[1] = k[1] ^ table_copy[k[14]];
            nk[2] = k[2] ^ table_copy[k[15]];
            nk[3] = k[3] ^ table_copy[k[12]];
            for (int i = 4; i < 16; i++) nk[i] = k[i] ^ nk[i - 4];
            k = nk;
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    s[w + 4 * c] = table_copy[b[w + 4 * ((c + w) & 3)]];
            if (r < n - 1 || final_mix_cfg)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    t = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ t ^ mul2(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ t ^ mul2(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ t ^ mul2(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ t ^ mul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) b[i] = s[i] ^ k[i];
        end
        for (int i = 0; i < 16; i++) pt[127 - 8 * i -: 8] = b[i];
        res.hi = pt[127:64];
        res.lo = pt[63:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign cipher_pending = cipher_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        cipher_t want;
        if (!rst_n)
        begin
            table_copy    = SBOX_INIT;
            rounds_cfg    = 4'd10;
            final_mix_cfg = 1'b0;
            alt_red_cfg   = 1'b0;
            key_hi_cfg    = '0;
            key_lo_cfg    = '0;
            cipher_queue.delete();
            fail_count    = 0;
        end
        else
        begin
            // Results are checked before this edge's inputs update the predictor.
            if (out_mon.valid && out_mon.ready)
            begin
                if (cipher_queue.size() == 0)
                begin
                    report_mismatch("unexpected result", out_mon.cipher_high, '0);
                end
                else
                begin
                    want = cipher_queue.pop_front();
                    if (out_mon.cipher_high !== want.hi)
                        report_mismatch("cipher_high", out_mon.cipher_high, want.hi);
                    if (out_mon.cipher_low !== want.lo)
                        report_mismatch("cipher_low", out_mon.cipher_low, want.lo);
                end
            end
            // An item taken at this edge still sees the registers as they were before it.
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.kind == KIND_SBOX_WRITE)
                    table_copy[in_mon.sbox_index] = in_mon.sbox_value;
                else
                    cipher_queue.push_back(encrypt_block(in_mon.block_high, in_mon.block_low));
            end
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    REG_ROUND_COUNT: rounds_cfg    = cfg_mon.data[3:0];
                    REG_FINAL_MIXES: final_mix_cfg = cfg_mon.data[0];
                    REG_REDUCTION:   alt_red_cfg   = cfg_mon.data[0];
                    REG_KEY_HIGH:    key_hi_cfg    = cfg_mon.data;
                    REG_KEY_LOW:     key_lo_cfg    = cfg_mon.data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/aes128_reduced_round_encryptor_test.sv =====
// Top of the encryptor testbench: clock, reset, stimulus, flow control and verdict.
module aes128_reduced_round_encryptor_test
    import aesrr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   cipher_pending;

    // Idle percentages for the sender and the receiver; changed between phases.
    int   send_idle_pct;
    int   recv_idle_pct;
    // While set, the receiver holds off completely so the pipeline fills up.
    bit   recv_hold;

    aesrr_in_if  in_ch ();
    aesrr_out_if out_ch ();
    aesrr_cfg_if cfg_ch ();

    aes128_reduced_round_encryptor uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    aesrr_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_ch.sink),
        .out_mon        (out_ch.sink),
        .cfg_mon        (cfg_ch.sink),
        .fail_count     (fail_count),
        .cipher_pending (cipher_pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The receiver decides its ready level at every falling edge.
    always @(negedge clk)
    begin
        if (recv_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drives one register write and waits for its transfer.
    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one item, with a random idle gap in front of it, and waits for the transfer.
    // Valid stays high across back-to-back items; it is only lowered during a gap.
    task automatic send_item(item_kind_t kind, logic [63:0] hi, logic [63:0] lo,
                             logic [7:0] idx, logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.block_high <= hi;
        in_ch.block_low  <= lo;
        in_ch.sbox_index <= idx;
        in_ch.sbox_value <= val;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic encrypt(logic [63:0] hi, logic [63:0] lo);
        send_item(KIND_ENCRYPT, hi, lo, 8'($urandom), 8'($urandom));
    endtask

    // Waits with the input lowered until every expected ciphertext has come back,
    // then lets the block finish any S-box write still in flight.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (cipher_pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic random_config();
        write_reg(REG_ROUND_COUNT, {$urandom, $urandom});
        write_reg(REG_FINAL_MIXES, 64'($urandom_range(1)));
        write_reg(REG_REDUCTION, 64'($urandom_range(1)));
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
    endtask

    // A random half of an encrypt block, biased toward all-zero and all-one values now and then.
    function automatic logic [63:0] rand_half();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_items(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(KIND_SBOX_WRITE, {$urandom, $urandom}, {$urandom, $urandom},
                          8'($urandom), 8'($urandom));
            else
                encrypt(rand_half(), rand_half());
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        recv_hold     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_ENCRYPT;
        in_ch.block_high = '0;
        in_ch.block_low  = '0;
        in_ch.sbox_index = '0;
        in_ch.sbox_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_ROUND_COUNT;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting from the reset settings: ten rounds, zero key,
        // standard S-box. The S-box clearing pass simply holds input ready low.
        encrypt('0, '0);
        encrypt('1, '1);
        encrypt(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        // The standard test key with full ten rounds, and the extremes of every register.
        write_reg(REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        encrypt(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd0);  // zero acts as a single round
        write_reg(REG_FINAL_MIXES, 64'd1);
        write_reg(REG_REDUCTION, 64'd1);
        encrypt(64'h8080808080808080, 64'hffffffffffffffff);
        encrypt('1, '0);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd15); // counts above ten saturate
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        encrypt('0, '1);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd11);
        encrypt(64'hdeadbeefcafef00d, 64'h0123456789abcdef);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd1);
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_KEY_LOW, '0);
        // Rewriting S-box entries at both ends of the index range; later blocks
        // must see the new values in both SubBytes and the key schedule.
        send_item(KIND_SBOX_WRITE, '0, '0, 8'h00, 8'hff);
        send_item(KIND_SBOX_WRITE, '1, '1, 8'hff, 8'h00);
        encrypt('0, '0);
        encrypt('1, '1);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd10);
        write_reg(REG_FINAL_MIXES, 64'd0);
        write_reg(REG_REDUCTION, 64'd0);
        encrypt(64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00);
        send_item(KIND_SBOX_WRITE, '0, '0, 8'h00, 8'h63);
        send_item(KIND_SBOX_WRITE, '0, '0, 8'hff, 8'h16);
        encrypt('0, '0);
        drain();

        // Random phases: receiver mostly idle, then sender mostly idle, then neither.
        send_idle_pct = 36;
        recv_idle_pct = 77;
        random_config();
        random_items(120);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd10);
        random_items(120);
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 36;
        random_config();
        random_items(120);
        drain();
        write_reg(REG_ROUND_COUNT, 64'd1);
        random_items(120);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        // Back pressure: the receiver holds off for a long stretch while items keep coming.
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(negedge clk);
                recv_hold = 1'b0;
            end
            begin
                random_items(20);
                in_ch.valid <= 1'b0;
            end
        join
        drain();
        random_config();
        random_items(230);
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
